/* src/pfdf_pkg.sv */
// ----------------------------------------------------------------------------
// Priority flood depression fill package
// Shared codes, default sizes and neighbor offset helpers.
// ----------------------------------------------------------------------------
package pfdf_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_ELEV_BITS  = 32;

   localparam int CFG_BITS = 9;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_FILL = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;
   localparam logic [1:0] ACT_SKIP = 2'd3;

   localparam logic RES_FILL = 1'b0;
   localparam logic RES_READ = 1'b1;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // Neighbors in raster order: three above, left, right, three below.
   function automatic logic nb_up(input logic [2:0] k);
      return k < 3'd3;
   endfunction

   function automatic logic nb_down(input logic [2:0] k);
      return k > 3'd4;
   endfunction

   function automatic logic nb_left(input logic [2:0] k);
      return (k == 3'd0) || (k == 3'd3) || (k == 3'd5);
   endfunction

   function automatic logic nb_right(input logic [2:0] k);
      return (k == 3'd2) || (k == 3'd4) || (k == 3'd7);
   endfunction

endpackage

/* src/priority_flood_depression_fill.sv */
// ----------------------------------------------------------------------------
// Priority flood depression fill
// Grid store, processed marks and a binary min-heap held in synchronous
// memories, walked by one sequencer that fills depressions on request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 word
//  req      in         req_valid / req_ready     action, index, elevation, no-data
//  rsp      out        rsp_valid / rsp_ready     kind, index, elevation, no-data
//  csr      in         csr_write                 register index, write data
//
// A load is written to the grid memory when it is accepted; a read passes
// through the registered grid memory read and the output register. Seeding
// checks each grid cell and its neighbors and sifts up each seed. Each pop
// reads the top and last heap entries and sifts down, and each of the eight
// neighbors is read and, if unprocessed, filled and sifted up, all in one heap memory.
// Reset is synchronous and clears control state only; no memory is cleared.
// A stalled result blocks reads and fills but not loads.
module priority_flood_depression_fill
   import pfdf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int ELEV_BITS  = DEF_ELEV_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [15:0]         req_cell_index,
   input  logic signed [31:0]  req_elevation_in,
   input  logic                req_nodata_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_result_kind,
   output logic [15:0]         rsp_cell_index_out,
   output logic signed [31:0]  rsp_elevation_out,
   output logic                rsp_nodata_out,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int CLW   = $clog2(MAX_WIDTH);
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int PW    = RW + DW;
   localparam int EB    = ELEV_BITS;
   localparam int KW    = EB + RW + CLW;
   localparam int NW    = AW + 1;
   localparam int CXW   = AW + 2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SC_ADDR, ST_SC_RD, ST_SC_CHK, ST_SN_NB, ST_SN_RD, ST_SN_DATA,
      ST_SC_NEXT, ST_PUSH, ST_PU_CHK, ST_PU_RD, ST_PU_CMP, ST_POP_CHK,
      ST_POP0, ST_POP1, ST_POP2, ST_PD_L, ST_PD_R, ST_PD_CMP, ST_NB_START,
      ST_NB_NB, ST_NB_RD, ST_NB_DATA, ST_NB_NEXT, ST_FIN
   } state_type;

   logic [EB:0]  cell_mem [CELLS];
   logic         proc_mem [CELLS];
   logic [KW-1:0] heap_mem [CELLS];

   state_type     state_ff, state_in;
   logic [CFG_BITS-1:0] wcfg_ff, hcfg_ff;
   logic [RW-1:0] r_ff, r_in, nr_ff, nr_in;
   logic [CLW-1:0] c_ff, c_in, nc_ff, nc_in;
   logic [2:0]    k_ff, k_in;
   logic [AW-1:0] addr_ff, addr_in, own_ff, own_in;
   logic [EB-1:0] own_elev_ff, own_elev_in;
   logic          seeding_ff, seeding_in;
   logic [KW-1:0] key_ff, key_in, top_ff, top_in, last_ff, last_in, lc_ff, lc_in;
   logic [NW-1:0] hi_ff, hi_in, hcnt_ff, hcnt_in;
   logic          rexist_ff, rexist_in;
   logic          pend_ff, pend_in, pend_oob_ff, pend_oob_in;
   logic [15:0]   pend_idx_ff, pend_idx_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic [15:0]   rsp_idx_ff, rsp_idx_in;
   logic [31:0]   rsp_elev_ff, rsp_elev_in;
   logic          rsp_nd_ff, rsp_nd_in;

   logic [EB:0]   cell_rd_ff;
   logic          proc_rd_ff;
   logic [KW-1:0] heap_rd_ff;

   logic          cell_we, proc_we, proc_wd, heap_we;
   logic [AW-1:0] cell_wa, cell_ra, proc_wa, heap_wa, heap_ra;
   logic [EB:0]   cell_wd;
   logic [KW-1:0] heap_wd;

   logic [DW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic          off, up, dn, lf, rt, rsp_free, accept, in_store, last_cell;
   logic [RW-1:0] nr;
   logic [CLW-1:0] nc;
   logic [AW-1:0] nbr_addr, cur_addr;
   logic [CXW-1:0] child;
   logic [KW-1:0] ch_key;
   logic [NW-1:0] ch_idx;
   logic [EB-1:0] spill, nb_elev, fill_elev;

   always_comb begin
      if (wcfg_ff == '0) begin
         w_eff = DW'(1);
      end else if (32'(wcfg_ff) > MAX_WIDTH) begin
         w_eff = DW'(MAX_WIDTH);
      end else begin
         w_eff = DW'(wcfg_ff);
      end
      if (hcfg_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(hcfg_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(hcfg_ff);
      end
   end

   assign up  = nb_up(k_ff);
   assign dn  = nb_down(k_ff);
   assign lf  = nb_left(k_ff);
   assign rt  = nb_right(k_ff);
   assign off = (up && r_ff == '0) || (dn && (HW'(r_ff) + HW'(1)) == h_eff) ||
                (lf && c_ff == '0) || (rt && (DW'(c_ff) + DW'(1)) == w_eff);
   assign nr  = up ? r_ff - RW'(1) : (dn ? r_ff + RW'(1) : r_ff);
   assign nc  = lf ? c_ff - CLW'(1) : (rt ? c_ff + CLW'(1) : c_ff);
   assign nbr_addr = AW'(PW'(nr) * PW'(w_eff)) + AW'(nc);
   assign cur_addr = AW'(PW'(r_ff) * PW'(w_eff)) + AW'(c_ff);
   assign last_cell = ((DW'(c_ff) + DW'(1)) == w_eff) && ((HW'(r_ff) + HW'(1)) == h_eff);

   assign child    = CXW'({hi_ff, 1'b1});
   assign ch_key   = (rexist_ff && heap_rd_ff < lc_ff) ? heap_rd_ff : lc_ff;
   assign ch_idx   = (rexist_ff && heap_rd_ff < lc_ff) ? NW'(child + CXW'(1)) : NW'(child);
   assign spill    = {~top_ff[KW-1], top_ff[KW-2:RW+CLW]};
   assign nb_elev  = cell_rd_ff[EB-1:0];
   assign fill_elev = ($signed(nb_elev) <= $signed(spill)) ? spill : nb_elev;

   assign in_store = 32'(req_cell_index) < CELLS;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   always_comb begin
      req_ready = 1'b0;
      if (state_ff == ST_IDLE) begin
         if (req_action == ACT_FILL || req_action == ACT_READ) begin
            req_ready = !pend_ff && rsp_free;
         end else begin
            req_ready = 1'b1;
         end
      end
   end
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      nr_in       = nr_ff;
      nc_in       = nc_ff;
      k_in        = k_ff;
      addr_in     = addr_ff;
      own_in      = own_ff;
      own_elev_in = own_elev_ff;
      seeding_in  = seeding_ff;
      key_in      = key_ff;
      top_in      = top_ff;
      last_in     = last_ff;
      lc_in       = lc_ff;
      hi_in       = hi_ff;
      hcnt_in     = hcnt_ff;
      rexist_in   = rexist_ff;
      pend_in     = 1'b0;
      pend_oob_in = pend_oob_ff;
      pend_idx_in = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_elev_in = rsp_elev_ff;
      rsp_nd_in   = rsp_nd_ff;
      cell_we     = 1'b0;
      cell_wa     = addr_ff;
      cell_wd     = {req_nodata_in, req_elevation_in[EB-1:0]};
      cell_ra     = addr_ff;
      proc_we     = 1'b0;
      proc_wa     = own_ff;
      proc_wd     = 1'b1;
      heap_we     = 1'b0;
      heap_wa     = AW'(hi_ff);
      heap_wd     = key_ff;
      heap_ra     = '0;

      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = RES_READ;
         rsp_idx_in   = pend_idx_ff;
         rsp_elev_in  = pend_oob_ff ? '0 : 32'($signed(cell_rd_ff[EB-1:0]));
         rsp_nd_in    = pend_oob_ff ? 1'b1 : cell_rd_ff[EB];
      end

      case (state_ff)
         ST_IDLE: begin
            cell_ra = AW'(req_cell_index);
            if (accept) begin
               case (req_action)
                  ACT_LOAD: begin
                     cell_we = in_store;
                     cell_wa = AW'(req_cell_index);
                  end
                  ACT_READ: begin
                     pend_in     = 1'b1;
                     pend_oob_in = !in_store;
                     pend_idx_in = req_cell_index;
                  end
                  ACT_FILL: begin
                     r_in     = '0;
                     c_in     = '0;
                     hcnt_in  = '0;
                     state_in = ST_SC_ADDR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SC_ADDR: begin
            own_in   = cur_addr;
            addr_in  = cur_addr;
            state_in = ST_SC_RD;
         end
         ST_SC_RD: begin
            state_in = ST_SC_CHK;
         end
         ST_SC_CHK: begin
            own_elev_in = cell_rd_ff[EB-1:0];
            k_in        = '0;
            if (cell_rd_ff[EB]) begin
               proc_we  = 1'b1;
               state_in = ST_SC_NEXT;
            end else begin
               state_in = ST_SN_NB;
            end
         end
         ST_SN_NB: begin
            if (off) begin
               proc_we    = 1'b1;
               key_in     = {~own_elev_ff[EB-1], own_elev_ff[EB-2:0], r_ff, c_ff};
               seeding_in = 1'b1;
               state_in   = ST_PUSH;
            end else begin
               addr_in  = nbr_addr;
               state_in = ST_SN_RD;
            end
         end
         ST_SN_RD: begin
            state_in = ST_SN_DATA;
         end
         ST_SN_DATA: begin
            if (cell_rd_ff[EB]) begin
               proc_we    = 1'b1;
               key_in     = {~own_elev_ff[EB-1], own_elev_ff[EB-2:0], r_ff, c_ff};
               seeding_in = 1'b1;
               state_in   = ST_PUSH;
            end else if (k_ff == 3'd7) begin
               proc_we  = 1'b1;
               proc_wd  = 1'b0;
               state_in = ST_SC_NEXT;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_SN_NB;
            end
         end
         ST_SC_NEXT: begin
            if (last_cell) begin
               state_in = ST_POP_CHK;
            end else if ((DW'(c_ff) + DW'(1)) == w_eff) begin
               c_in     = '0;
               r_in     = r_ff + RW'(1);
               state_in = ST_SC_ADDR;
            end else begin
               c_in     = c_ff + CLW'(1);
               state_in = ST_SC_ADDR;
            end
         end
         ST_PUSH: begin
            if (32'(hcnt_ff) >= CELLS) begin
               state_in = seeding_ff ? ST_SC_NEXT : ST_NB_NEXT;
            end else begin
               hi_in    = hcnt_ff;
               hcnt_in  = hcnt_ff + NW'(1);
               state_in = ST_PU_CHK;
            end
         end
         ST_PU_CHK: begin
            if (hi_ff == '0) begin
               heap_we  = 1'b1;
               state_in = seeding_ff ? ST_SC_NEXT : ST_NB_NEXT;
            end else begin
               state_in = ST_PU_RD;
            end
         end
         ST_PU_RD: begin
            heap_ra  = AW'((hi_ff - NW'(1)) >> 1);
            state_in = ST_PU_CMP;
         end
         ST_PU_CMP: begin
            heap_we = 1'b1;
            if (heap_rd_ff <= key_ff) begin
               state_in = seeding_ff ? ST_SC_NEXT : ST_NB_NEXT;
            end else begin
               heap_wd  = heap_rd_ff;
               hi_in    = (hi_ff - NW'(1)) >> 1;
               state_in = ST_PU_CHK;
            end
         end
         ST_POP_CHK: begin
            state_in = (hcnt_ff == '0) ? ST_FIN : ST_POP0;
         end
         ST_POP0: begin
            heap_ra  = '0;
            state_in = ST_POP1;
         end
         ST_POP1: begin
            top_in   = heap_rd_ff;
            heap_ra  = AW'(hcnt_ff - NW'(1));
            state_in = ST_POP2;
         end
         ST_POP2: begin
            last_in  = heap_rd_ff;
            hcnt_in  = hcnt_ff - NW'(1);
            hi_in    = '0;
            state_in = ST_PD_L;
         end
         ST_PD_L: begin
            if (child >= CXW'(hcnt_ff)) begin
               heap_we  = 1'b1;
               heap_wd  = last_ff;
               state_in = ST_NB_START;
            end else begin
               heap_ra  = AW'(child);
               state_in = ST_PD_R;
            end
         end
         ST_PD_R: begin
            lc_in     = heap_rd_ff;
            rexist_in = (child + CXW'(1)) < CXW'(hcnt_ff);
            heap_ra   = AW'(child + CXW'(1));
            state_in  = ST_PD_CMP;
         end
         ST_PD_CMP: begin
            heap_we = 1'b1;
            if (last_ff <= ch_key) begin
               heap_wd  = last_ff;
               state_in = ST_NB_START;
            end else begin
               heap_wd  = ch_key;
               hi_in    = ch_idx;
               state_in = ST_PD_L;
            end
         end
         ST_NB_START: begin
            r_in     = top_ff[RW+CLW-1:CLW];
            c_in     = top_ff[CLW-1:0];
            k_in     = '0;
            state_in = ST_NB_NB;
         end
         ST_NB_NB: begin
            if (off) begin
               state_in = ST_NB_NEXT;
            end else begin
               addr_in  = nbr_addr;
               nr_in    = nr;
               nc_in    = nc;
               state_in = ST_NB_RD;
            end
         end
         ST_NB_RD: begin
            state_in = ST_NB_DATA;
         end
         ST_NB_DATA: begin
            if (proc_rd_ff) begin
               state_in = ST_NB_NEXT;
            end else begin
               cell_we    = 1'b1;
               cell_wd    = {cell_rd_ff[EB], fill_elev};
               proc_we    = 1'b1;
               proc_wa    = addr_ff;
               key_in     = {~fill_elev[EB-1], fill_elev[EB-2:0], nr_ff, nc_ff};
               seeding_in = 1'b0;
               state_in   = ST_PUSH;
            end
         end
         ST_NB_NEXT: begin
            if (k_ff == 3'd7) begin
               state_in = ST_POP_CHK;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_NB_NB;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RES_FILL;
               rsp_idx_in   = '0;
               rsp_elev_in  = '0;
               rsp_nd_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      cell_rd_ff <= cell_mem[cell_ra];
   end

   always_ff @(posedge clock) begin
      if (proc_we) begin
         proc_mem[proc_wa] <= proc_wd;
      end
      proc_rd_ff <= proc_mem[cell_ra];
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_wa] <= heap_wd;
      end
      heap_rd_ff <= heap_mem[heap_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wcfg_ff      <= CFG_BITS'(MAX_WIDTH > 256 ? 256 : MAX_WIDTH);
         hcfg_ff      <= CFG_BITS'(MAX_HEIGHT > 256 ? 256 : MAX_HEIGHT);
         hcnt_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seeding_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hcnt_ff      <= hcnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         seeding_ff   <= seeding_in;
         if (csr_write && csr_index == CSR_GRID_WIDTH) begin
            wcfg_ff <= csr_wdata;
         end
         if (csr_write && csr_index == CSR_GRID_HEIGHT) begin
            hcfg_ff <= csr_wdata;
         end
      end
      r_ff        <= r_in;
      c_ff        <= c_in;
      nr_ff       <= nr_in;
      nc_ff       <= nc_in;
      k_ff        <= k_in;
      addr_ff     <= addr_in;
      own_ff      <= own_in;
      own_elev_ff <= own_elev_in;
      key_ff      <= key_in;
      top_ff      <= top_in;
      last_ff     <= last_in;
      lc_ff       <= lc_in;
      hi_ff       <= hi_in;
      rexist_ff   <= rexist_in;
      pend_oob_ff <= pend_oob_in;
      pend_idx_ff <= pend_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_elev_ff <= rsp_elev_in;
      rsp_nd_ff   <= rsp_nd_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_cell_index_out = rsp_idx_ff;
   assign rsp_elevation_out  = rsp_elev_ff;
   assign rsp_nodata_out     = rsp_nd_ff;

endmodule

/* src/pfdf_checker.sv */
// ----------------------------------------------------------------------------
// Priority flood depression fill port checker
// Watches the top level ports and reports handshake and result slips.
// ----------------------------------------------------------------------------
module pfdf_checker
   import pfdf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [15:0] rsp_cell_index_out,
   input logic [31:0] rsp_elevation_out,
   input logic        rsp_nodata_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RES_FILL |->
      rsp_cell_index_out == '0 && rsp_elevation_out == '0 && !rsp_nodata_out)
      else $error("fill result carries data");

   a_read_room: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_READ || req_action == ACT_FILL)
      |-> !rsp_valid || rsp_ready)
      else $error("read or fill taken while a result is stalled");

endmodule

bind priority_flood_depression_fill pfdf_checker u_pfdf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_action         (req_action),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_cell_index_out (rsp_cell_index_out),
   .rsp_elevation_out  (rsp_elevation_out),
   .rsp_nodata_out     (rsp_nodata_out)
);
